>>> src/extended_gcd_bezout_coefficients_unit_defines.svh
// Assertion macros shared by the extended GCD unit.
`ifndef EXTENDED_GCD_BEZOUT_COEFFICIENTS_UNIT_DEFINES_SVH
`define EXTENDED_GCD_BEZOUT_COEFFICIENTS_UNIT_DEFINES_SVH

// Same-cycle implication, reset masked.
`define EGCD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("egcd: same-cycle check failed");

// Next-cycle implication, reset masked.
`define EGCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("egcd: next-cycle check failed");

`endif

>>> src/egcd_pkg.sv
`default_nettype none
package egcd_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int COEFF_W    = DATA_WIDTH + 1;
  localparam int CNT_W      = $clog2(DATA_WIDTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SWAP,
    ST_DONE
  } egcd_state_t;

  // sequencer -> datapath
  typedef struct packed {
    logic load;
    logic div;
    logic swap;
    logic done;
    logic busy;
  } egcd_ctrl_t;

  // datapath -> sequencer
  typedef struct packed {
    logic b_zero;
    logic rem_zero;
  } egcd_status_t;

endpackage
`default_nettype wire

>>> src/egcd_step_unit.sv
`default_nettype none
module egcd_step_unit (
  input  logic [egcd_pkg::DATA_WIDTH-1:0] rem,
  input  logic                            bit_in,
  input  logic [egcd_pkg::DATA_WIDTH-1:0] den,
  input  logic [egcd_pkg::COEFF_W-1:0]    px,
  input  logic [egcd_pkg::COEFF_W-1:0]    py,
  input  logic [egcd_pkg::COEFF_W-1:0]    xc,
  input  logic [egcd_pkg::COEFF_W-1:0]    yc,
  input  logic [egcd_pkg::COEFF_W-1:0]    xp,
  input  logic [egcd_pkg::COEFF_W-1:0]    yp,
  output logic [egcd_pkg::DATA_WIDTH-1:0] rem_out,
  output logic [egcd_pkg::COEFF_W-1:0]    px_out,
  output logic [egcd_pkg::COEFF_W-1:0]    py_out,
  output logic [egcd_pkg::COEFF_W-1:0]    x_new,
  output logic [egcd_pkg::COEFF_W-1:0]    y_new
);

  logic [egcd_pkg::DATA_WIDTH:0] rem_sh;
  logic [egcd_pkg::DATA_WIDTH:0] rem_sub;
  logic                          ge;

  // one restoring division step
  assign rem_sh  = {rem, bit_in};
  assign rem_sub = rem_sh - {1'b0, den};
  assign ge      = (rem_sh >= {1'b0, den});
  assign rem_out = ge ? rem_sub[egcd_pkg::DATA_WIDTH-1:0] : rem_sh[egcd_pkg::DATA_WIDTH-1:0];

  // Horner accumulation of q*xc and q*yc, quotient bits MSB first
  assign px_out = {px[egcd_pkg::COEFF_W-2:0], 1'b0} + (ge ? xc : '0);
  assign py_out = {py[egcd_pkg::COEFF_W-2:0], 1'b0} + (ge ? yc : '0);

  // coefficient update at the end of a step
  assign x_new = xp - px;
  assign y_new = yp - py;

endmodule
`default_nettype wire

>>> src/egcd_seq.sv
`default_nettype none
`include "extended_gcd_bezout_coefficients_unit_defines.svh"
module egcd_seq (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  egcd_pkg::egcd_status_t   status,
  output egcd_pkg::egcd_ctrl_t     ctrl
);

  egcd_pkg::egcd_state_t state, state_next;
  logic [egcd_pkg::CNT_W-1:0] cnt;
  logic                       cnt_last;

  assign cnt_last = (cnt == egcd_pkg::CNT_W'(egcd_pkg::DATA_WIDTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= egcd_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == egcd_pkg::ST_DIV) begin
        cnt <= cnt_last ? '0 : cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      egcd_pkg::ST_IDLE: begin
        if (start) begin
          state_next = status.b_zero ? egcd_pkg::ST_DONE : egcd_pkg::ST_DIV;
        end
      end
      egcd_pkg::ST_DIV: begin
        if (cnt_last) begin
          state_next = egcd_pkg::ST_SWAP;
        end
      end
      egcd_pkg::ST_SWAP: begin
        state_next = status.rem_zero ? egcd_pkg::ST_DONE : egcd_pkg::ST_DIV;
      end
      egcd_pkg::ST_DONE: begin
        state_next = egcd_pkg::ST_IDLE;
      end
      default: begin
        state_next = egcd_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl = '0;
    case (state)
      egcd_pkg::ST_IDLE: begin
        ctrl.load = start;
      end
      egcd_pkg::ST_DIV: begin
        ctrl.div  = 1'b1;
        ctrl.busy = 1'b1;
      end
      egcd_pkg::ST_SWAP: begin
        ctrl.swap = 1'b1;
        ctrl.busy = 1'b1;
      end
      egcd_pkg::ST_DONE: begin
        ctrl.done = 1'b1;
        ctrl.busy = 1'b1;
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

  `EGCD_ASSERT_NEXT(a_div_ends_in_swap, clk, rst, ctrl.div && cnt_last, ctrl.swap)
  `EGCD_ASSERT_NEXT(a_done_single, clk, rst, ctrl.done, !ctrl.done && !ctrl.busy)
  `EGCD_ASSERT_NEXT(a_load_goes_busy, clk, rst, ctrl.load, ctrl.busy)
  `EGCD_ASSERT_NOW(a_load_only_idle, clk, rst, ctrl.load, !ctrl.busy)

endmodule
`default_nettype wire

>>> src/extended_gcd_bezout_coefficients_unit.sv
// Between the start transfer and the done strobe the unit runs S Euclid steps,
//   S being 0 when second_value is zero; each step is the divide state, then the swap state.
// Busy stays high until the result strobe has gone, so the next transfer lands in
//   the cycle after the strobe.
// The shared divide/accumulate step unit retires one quotient bit a cycle.
// Reset (rst, synchronous, active high) returns the sequencer to idle; no clearing pass.
// Results appear for one cycle with done high; the receiver cannot stall them.
`default_nettype none
module extended_gcd_bezout_coefficients_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [egcd_pkg::DATA_WIDTH-1:0]       first_value,
  input  logic [egcd_pkg::DATA_WIDTH-1:0]       second_value,
  output logic                                  done,
  output logic signed [egcd_pkg::COEFF_W-1:0]   coeff_first,
  output logic signed [egcd_pkg::COEFF_W-1:0]   coeff_second
);

  egcd_pkg::egcd_ctrl_t   ctrl;
  egcd_pkg::egcd_status_t status;

  // working pair: numerator bits shift out MSB first, den is the divisor
  logic [egcd_pkg::DATA_WIDTH-1:0] numsh;
  logic [egcd_pkg::DATA_WIDTH-1:0] den;
  logic [egcd_pkg::DATA_WIDTH-1:0] rem;
  // coefficient pairs, two's complement modulo 2^COEFF_W
  logic [egcd_pkg::COEFF_W-1:0]    xp, xc, yp, yc;
  // running q*xc and q*yc for the step in progress
  logic [egcd_pkg::COEFF_W-1:0]    px, py;

  logic [egcd_pkg::DATA_WIDTH-1:0] rem_next;
  logic [egcd_pkg::COEFF_W-1:0]    px_next, py_next, x_new, y_new;

  assign status.b_zero   = (second_value == '0);
  assign status.rem_zero = (rem == '0);

  egcd_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .ctrl   (ctrl)
  );

  egcd_step_unit u_step (
    .rem     (rem),
    .bit_in  (numsh[egcd_pkg::DATA_WIDTH-1]),
    .den     (den),
    .px      (px),
    .py      (py),
    .xc      (xc),
    .yc      (yc),
    .xp      (xp),
    .yp      (yp),
    .rem_out (rem_next),
    .px_out  (px_next),
    .py_out  (py_next),
    .x_new   (x_new),
    .y_new   (y_new)
  );

  // Datapath. Load seeds (a, b) with x = (1, 0), y = (0, 1); each divide cycle
  // retires one quotient bit; swap moves to (b, r) and closes the coefficient update.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      numsh <= first_value;
      den   <= second_value;
      rem   <= '0;
      px    <= '0;
      py    <= '0;
      xp    <= egcd_pkg::COEFF_W'(1);
      xc    <= '0;
      yp    <= '0;
      yc    <= egcd_pkg::COEFF_W'(1);
    end else if (ctrl.div) begin
      numsh <= {numsh[egcd_pkg::DATA_WIDTH-2:0], 1'b0};
      rem   <= rem_next;
      px    <= px_next;
      py    <= py_next;
    end else if (ctrl.swap) begin
      numsh <= den;
      den   <= rem;
      rem   <= '0;
      px    <= '0;
      py    <= '0;
      xp    <= xc;
      xc    <= x_new;
      yp    <= yc;
      yc    <= y_new;
    end
  end

  assign busy         = ctrl.busy;
  assign done         = ctrl.done;
  assign coeff_first  = $signed(xp);
  assign coeff_second = $signed(yp);

endmodule
`default_nettype wire
